@@ sv/ctcgd_pkg.sv @@
package ctcgd_pkg;

    localparam int PROB_W   = 16;
    localparam int CLASS_W  = 13;
    localparam int STEP_W   = 8;
    localparam int SCORE_W  = 24;
    localparam int COUNT_W  = 9;
    localparam int POS_W    = 9;
    localparam int NCLS_W   = 14;
    localparam int NSTEP_W  = 9;
    localparam int CFG_W    = 14;
    localparam int CFG_IDX_W = 1;

    localparam int MAX_CLASSES = 8192;
    localparam int MAX_STEPS   = 256;

    localparam logic [NCLS_W-1:0]  NUM_CLASSES_RST = NCLS_W'(6625);
    localparam logic [NSTEP_W-1:0] NUM_STEPS_RST   = NSTEP_W'(40);

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_CLASSES = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_STEPS   = 1'b1;

    localparam logic KIND_SYMBOL  = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    localparam logic [SCORE_W-1:0] SCORE_MAX = {SCORE_W{1'b1}};
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [POS_W-1:0]   POS_NONE  = {POS_W{1'b1}};

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int OUT_DATA_W  = 80;

    typedef struct packed {
        logic                emit;
        logic                frame_end;
        logic [CLASS_W-1:0]  class_idx;
        logic [STEP_W-1:0]   step_idx;
        logic [PROB_W-1:0]   prob;
    } t_step_rec;

endpackage

@@ sv/ctcgd_front.sv @@
module ctcgd_front
    import ctcgd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_valid,
    input  logic [PROB_W-1:0]    i_prob,
    output logic                 o_ready,
    input  logic                 i_queue_full,
    output logic                 o_push,
    output t_step_rec            o_rec
);

    logic [NCLS_W-1:0]  r_num_classes;
    logic [NSTEP_W-1:0] r_num_steps;
    logic [PROB_W-1:0]  r_best_prob;
    logic [CLASS_W-1:0] r_best_class;
    logic [CLASS_W-1:0] r_class_cnt;
    logic [STEP_W-1:0]  r_step_cnt;
    logic [CLASS_W-1:0] r_prev_winner;

    logic [NCLS_W-1:0]  eff_classes;
    logic [NSTEP_W-1:0] eff_steps;
    logic               accept;
    logic               take;
    logic [PROB_W-1:0]  n_best_prob;
    logic [CLASS_W-1:0] n_best_class;
    logic               step_end;
    logic               frame_end;
    logic               emit;

    always_comb begin
        if (r_num_classes < NCLS_W'(2)) begin
            eff_classes = NCLS_W'(2);
        end else if (r_num_classes > NCLS_W'(MAX_CLASSES)) begin
            eff_classes = NCLS_W'(MAX_CLASSES);
        end else begin
            eff_classes = r_num_classes;
        end
        if (r_num_steps < NSTEP_W'(1)) begin
            eff_steps = NSTEP_W'(1);
        end else if (r_num_steps > NSTEP_W'(MAX_STEPS)) begin
            eff_steps = NSTEP_W'(MAX_STEPS);
        end else begin
            eff_steps = r_num_steps;
        end
    end

    assign o_ready = !i_queue_full;
    assign accept  = i_valid && !i_queue_full;

    assign take         = (r_class_cnt == '0) || (i_prob > r_best_prob);
    assign n_best_prob  = take ? i_prob : r_best_prob;
    assign n_best_class = take ? r_class_cnt : r_best_class;
    assign step_end     = ({1'b0, r_class_cnt} + NCLS_W'(1)) >= eff_classes;
    assign frame_end    = ({1'b0, r_step_cnt} + NSTEP_W'(1)) >= eff_steps;
    assign emit         = (n_best_class != '0) && (n_best_class != r_prev_winner);

    assign o_push            = accept && step_end;
    assign o_rec.emit        = emit;
    assign o_rec.frame_end   = frame_end;
    assign o_rec.class_idx   = n_best_class;
    assign o_rec.step_idx    = r_step_cnt;
    assign o_rec.prob        = n_best_prob;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_classes <= NUM_CLASSES_RST;
            r_num_steps   <= NUM_STEPS_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_NUM_CLASSES: r_num_classes <= i_cfg_data;
                CFG_NUM_STEPS:   r_num_steps   <= i_cfg_data[NSTEP_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_prob   <= '0;
            r_best_class  <= '0;
            r_class_cnt   <= '0;
            r_step_cnt    <= '0;
            r_prev_winner <= '0;
        end else if (accept) begin
            r_best_prob  <= n_best_prob;
            r_best_class <= n_best_class;
            if (!step_end) begin
                r_class_cnt <= r_class_cnt + CLASS_W'(1);
            end else begin
                r_class_cnt <= '0;
                if (frame_end) begin
                    r_step_cnt    <= '0;
                    r_prev_winner <= '0;
                end else begin
                    r_step_cnt    <= r_step_cnt + STEP_W'(1);
                    r_prev_winner <= n_best_class;
                end
            end
        end
    end

endmodule

@@ sv/ctcgd_queue.sv @@
module ctcgd_queue
    import ctcgd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_step_rec i_rec,
    output logic      o_full,
    input  logic      i_pop,
    output logic      o_nonempty,
    output t_step_rec o_rec
);

    t_step_rec         r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    logic do_pop;

    assign o_full     = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_nonempty = (r_count != '0);
    assign o_rec      = r_mem[r_rd_ptr];
    assign do_pop     = i_pop && o_nonempty;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (!i_push && do_pop) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

endmodule

@@ sv/ctcgd_back.sv @@
module ctcgd_back
    import ctcgd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_nonempty,
    input  t_step_rec             i_rec,
    output logic                  o_pop,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic                  o_kind,
    output logic [CLASS_W-1:0]    o_class_index,
    output logic [STEP_W-1:0]     o_step_index,
    output logic [PROB_W-1:0]     o_symbol_prob,
    output logic [SCORE_W-1:0]    o_score_sum,
    output logic [COUNT_W-1:0]    o_symbol_count,
    output logic [POS_W-1:0]      o_last_pos,
    output logic                  o_frame_end
);

    logic               r_valid;
    logic               r_kind;
    logic [CLASS_W-1:0] r_class;
    logic [STEP_W-1:0]  r_step;
    logic [PROB_W-1:0]  r_prob;
    logic [SCORE_W-1:0] r_sum;
    logic [COUNT_W-1:0] r_cnt;
    logic [POS_W-1:0]   r_pos;
    logic               r_last;

    logic               r_sum_pend;
    logic [SCORE_W-1:0] r_acc;
    logic [COUNT_W-1:0] r_sym_cnt;
    logic [POS_W-1:0]   r_last_step;

    logic               can_load;
    logic               pop;
    logic [SCORE_W:0]   acc_sum;
    logic [SCORE_W-1:0] n_acc;
    logic [COUNT_W-1:0] n_sym_cnt;

    assign can_load = !r_valid || i_ready;
    assign pop = i_nonempty && !r_sum_pend
                 && (can_load || (!i_rec.emit && !i_rec.frame_end));
    assign o_pop = pop;

    assign acc_sum   = {1'b0, r_acc} + (SCORE_W+1)'(i_rec.prob);
    assign n_acc     = acc_sum[SCORE_W] ? SCORE_MAX : acc_sum[SCORE_W-1:0];
    assign n_sym_cnt = (r_sym_cnt == COUNT_MAX) ? r_sym_cnt : r_sym_cnt + COUNT_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= 1'b0;
            r_sum_pend  <= 1'b0;
            r_acc       <= '0;
            r_sym_cnt   <= '0;
            r_last_step <= POS_NONE;
        end else begin
            if (r_sum_pend && can_load) begin
                r_valid     <= 1'b1;
                r_kind      <= KIND_SUMMARY;
                r_class     <= '0;
                r_step      <= '0;
                r_prob      <= '0;
                r_sum       <= r_acc;
                r_cnt       <= r_sym_cnt;
                r_pos       <= r_last_step;
                r_last      <= 1'b1;
                r_sum_pend  <= 1'b0;
                r_acc       <= '0;
                r_sym_cnt   <= '0;
                r_last_step <= POS_NONE;
            end else if (pop && i_rec.emit) begin
                r_valid     <= 1'b1;
                r_kind      <= KIND_SYMBOL;
                r_class     <= i_rec.class_idx;
                r_step      <= i_rec.step_idx;
                r_prob      <= i_rec.prob;
                r_sum       <= '0;
                r_cnt       <= '0;
                r_pos       <= '0;
                r_last      <= 1'b0;
                r_acc       <= n_acc;
                r_sym_cnt   <= n_sym_cnt;
                r_last_step <= {1'b0, i_rec.step_idx};
                r_sum_pend  <= i_rec.frame_end;
            end else if (pop && i_rec.frame_end) begin
                r_valid     <= 1'b1;
                r_kind      <= KIND_SUMMARY;
                r_class     <= '0;
                r_step      <= '0;
                r_prob      <= '0;
                r_sum       <= r_acc;
                r_cnt       <= r_sym_cnt;
                r_pos       <= r_last_step;
                r_last      <= 1'b1;
                r_acc       <= '0;
                r_sym_cnt   <= '0;
                r_last_step <= POS_NONE;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_valid        = r_valid;
    assign o_kind         = r_kind;
    assign o_class_index  = r_class;
    assign o_step_index   = r_step;
    assign o_symbol_prob  = r_prob;
    assign o_score_sum    = r_sum;
    assign o_symbol_count = r_cnt;
    assign o_last_pos     = r_pos;
    assign o_frame_end    = r_last;

endmodule

@@ sv/ctc_greedy_decoder_unit.sv @@
// Greedy CTC decoder. Class probabilities enter on the slave stream, one item per
// cycle, class by class within a time step and step by step within a frame.
// The front tracks the per-step maximum and, at the last class of a step, pushes
// a step record into a four-entry queue. The back turns records into results:
// a symbol item (tuser 0) when the winner is neither blank nor a repeat, and a
// summary item (tuser 1, tlast 1) at the end of each frame.
// A symbol's step record passes through the queue and then the output register
// before tvalid rises; a frame summary follows the frame's final symbol. Input
// throughput is one item per cycle while the receiver keeps tready high, since
// each step record needs at most two output items and a step spans at least two
// input items. When the receiver stalls, the output register holds its item, the
// queue fills, and the slave tready drops once the queue is full.
// Configuration writes take effect at once and must be made only while the
// block is idle, which the block itself does not enforce. A synchronous reset
// clears all frame state and restores num_classes to 6625 and num_steps to 40;
// no result is pending after reset.
module ctc_greedy_decoder_unit
    import ctcgd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_W-1:0]      i_cfg_data,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // probability[15:0]
    input  logic [PROB_W-1:0]     i_s_axis_tdata,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // class_index[12:0], step_index[20:13], symbol_prob[36:21], score_sum[60:37],
    // symbol_count[69:61], last_pos[78:70], zero[79]
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    // kind[0]
    output logic                  o_m_axis_tuser,
    output logic                  o_m_axis_tlast
);

    logic               queue_full;
    logic               push;
    t_step_rec          push_rec;
    logic               pop;
    logic               nonempty;
    t_step_rec          head_rec;
    logic [CLASS_W-1:0] class_index;
    logic [STEP_W-1:0]  step_index;
    logic [PROB_W-1:0]  symbol_prob;
    logic [SCORE_W-1:0] score_sum;
    logic [COUNT_W-1:0] symbol_count;
    logic [POS_W-1:0]   last_pos;

    ctcgd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_s_axis_tvalid),
        .i_prob       (i_s_axis_tdata),
        .o_ready      (o_s_axis_tready),
        .i_queue_full (queue_full),
        .o_push       (push),
        .o_rec        (push_rec)
    );

    ctcgd_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_rec      (push_rec),
        .o_full     (queue_full),
        .i_pop      (pop),
        .o_nonempty (nonempty),
        .o_rec      (head_rec)
    );

    ctcgd_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_nonempty     (nonempty),
        .i_rec          (head_rec),
        .o_pop          (pop),
        .o_valid        (o_m_axis_tvalid),
        .i_ready        (i_m_axis_tready),
        .o_kind         (o_m_axis_tuser),
        .o_class_index  (class_index),
        .o_step_index   (step_index),
        .o_symbol_prob  (symbol_prob),
        .o_score_sum    (score_sum),
        .o_symbol_count (symbol_count),
        .o_last_pos     (last_pos),
        .o_frame_end    (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {1'b0, last_pos, symbol_count, score_sum, symbol_prob,
                             step_index, class_index};

endmodule
